@@ rtl/spbe_pkg.sv @@
// Shared types and constants for the spin precession block.
// No dependencies; imported by every rtl module of the block.
`timescale 1ns / 1ps
package spbe_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int SPIN_W         = 32;
   localparam int MUL_W          = 33;
   localparam int PROD_W         = 2 * MUL_W;
   localparam int DEN_W          = 45;
   localparam int NUM_W          = 64;

   localparam logic [31:0] GAIN_RESET = 32'd12006195;
   localparam logic        NORM_RESET = 1'b1;

   typedef enum logic [0:0] {
      CSR_GAIN = 1'b0,
      CSR_NORM = 1'b1
   } csr_index_type;

   // multiply micro-ops
   typedef enum logic [2:0] {
      MOP_NONE,
      MOP_B,
      MOP_Q,
      MOP_D,
      MOP_NP,
      MOP_NM,
      MOP_NDB,
      MOP_SQ
   } mop_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREC,
      ST_PFLUSH,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SQ,
      ST_SFLUSH,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      mop_type    mop;
      logic [1:0] idx;
      logic       src_r;
      logic       sqrt_start;
      logic       div_start;
      logic       div_unit;
      logic       div_store;
      logic       set_zero;
      logic       publish;
   } cmd_type;

   typedef struct packed {
      logic norm;
      logic div_done;
      logic sqrt_done;
      logic mag_zero;
      logic out_busy;
   } status_type;

endpackage

@@ rtl/spbe_div.sv @@
// Restoring divider, one quotient bit per cycle, with 32-bit signed saturation.
// Depends on spbe_pkg.
`timescale 1ns / 1ps
module spbe_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [spbe_pkg::NUM_W-1:0]   num_mag,
   input  logic                         num_neg,
   input  logic                         unit,      // 1: shift 30, 0: shift 20
   input  logic [spbe_pkg::DEN_W-1:0]   den,
   output logic                         done,
   output logic signed [spbe_pkg::SPIN_W-1:0] quot
);
   import spbe_pkg::*;

   localparam int DVD_W = NUM_W + 30;
   localparam int LOW_W = SPIN_W + 1;
   localparam int HI_W  = DVD_W - LOW_W;
   localparam logic [LOW_W-1:0] Q_LIM = LOW_W'(64'd1 << (SPIN_W - 1));
   localparam logic [LOW_W-1:0] Q_MAX = Q_LIM - LOW_W'(1);

   logic [DVD_W-1:0] dvd;
   logic [HI_W-1:0]  hi;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [LOW_W-1:0] low_ff, low_in, quo_ff, quo_in;
   logic             neg_ff, neg_in, ovf_ff, ovf_in;
   logic [DEN_W:0]   trial;
   logic             ge;
   logic [LOW_W-1:0] qc, qneg;

   always_comb begin
      dvd   = unit ? ({30'b0, num_mag} << 30) : ({30'b0, num_mag} << 20);
      hi    = dvd[DVD_W-1:LOW_W];
      trial = {rem_ff, low_ff[LOW_W-1]};
      ge    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(LOW_W - 1);
         rem_in  = hi[DEN_W-1:0];    // below den unless overflow
         low_in  = dvd[LOW_W-1:0];
         quo_in  = '0;
         den_in  = den;
         neg_in  = num_neg;
         ovf_in  = hi >= HI_W'(den);
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         low_in = {low_ff[LOW_W-2:0], 1'b0};
         quo_in = {quo_ff[LOW_W-2:0], ge};
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
   end

   // clamp magnitude to 2^31, then to the signed range
   always_comb begin
      qc   = (ovf_ff || quo_ff > Q_LIM) ? Q_LIM : quo_ff;
      qneg = LOW_W'(0) - qc;
      if (neg_ff)
         quot = signed'(qneg[SPIN_W-1:0]);
      else
         quot = signed'(((qc > Q_MAX) ? Q_MAX[SPIN_W-1:0] : qc[SPIN_W-1:0]));
   end

   assign done = done_ff;

endmodule

@@ rtl/spbe_isqrt.sv @@
// Integer floor square root of a 64-bit value, one result bit per cycle.
// Depends on spbe_pkg.
`timescale 1ns / 1ps
module spbe_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [spbe_pkg::NUM_W-1:0] value,
   output logic                       done,
   output logic [spbe_pkg::SPIN_W-1:0] root
);
   import spbe_pkg::*;

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [NUM_W-1:0] v_ff, v_in, r_ff, r_in, bit_ff, bit_in, rb;

   always_comb begin
      rb      = r_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd31;
         v_in    = value;
         r_in    = '0;
         bit_in  = NUM_W'(1) << (NUM_W - 2);
      end else if (busy_ff) begin
         if (v_ff >= rb) begin
            v_in = v_ff - rb;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[SPIN_W-1:0];

endmodule

@@ rtl/spbe_datapath.sv @@
// Datapath: shared multiplier, accumulators, divider and square root, output register.
// Depends on spbe_pkg, spbe_div and spbe_isqrt.
`timescale 1ns / 1ps
module spbe_datapath #(
   parameter int DATA_WIDTH = spbe_pkg::DATA_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  spbe_pkg::cmd_type                cmd,
   output spbe_pkg::status_type             status,
   input  logic [31:0]                      gain,
   input  logic                             norm,
   input  logic [DATA_WIDTH-1:0]            field_x,
   input  logic [DATA_WIDTH-1:0]            field_y,
   input  logic [DATA_WIDTH-1:0]            field_z,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [spbe_pkg::SPIN_W-1:0]      spin_x,
   output logic [spbe_pkg::SPIN_W-1:0]      spin_y,
   output logic [spbe_pkg::SPIN_W-1:0]      spin_z,
   output logic                             zero_field
);
   import spbe_pkg::*;

   localparam int EXT_W = (DATA_WIDTH > SPIN_W) ? DATA_WIDTH : SPIN_W + 1;
   localparam logic signed [EXT_W-1:0] F_MAX = EXT_W'((64'sd1 <<< (SPIN_W - 1)) - 64'sd1);
   localparam logic signed [EXT_W-1:0] F_MIN = EXT_W'(-(64'sd1 <<< (SPIN_W - 1)));
   localparam logic signed [PROD_W-1:0] B_MAX = PROD_W'(64'sd2047 <<< 20);
   localparam logic signed [PROD_W-1:0] B_MIN = -B_MAX;

   logic signed [DATA_WIDTH-1:0] field_in [3];
   logic signed [EXT_W-1:0]      fext [3];
   logic signed [SPIN_W-1:0]     fsat [3];

   logic signed [SPIN_W-1:0] f_ff [3];
   logic signed [SPIN_W-1:0] s_ff [3];
   logic signed [SPIN_W-1:0] b_ff [3];
   logic signed [SPIN_W-1:0] r_ff [3];
   logic signed [NUM_W-1:0]  n_ff [3];
   logic signed [SPIN_W-1:0] d_ff;
   logic [NUM_W-1:0]         q_ff, ss_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   mop_type                  tag_op_ff;
   logic [1:0]               tag_idx_ff;

   logic signed [SPIN_W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic                     out_zero_ff, zero_ff;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [1:0]               jx, kx;
   logic signed [MUL_W-1:0]  ma, mc;
   logic signed [SPIN_W-1:0] vsrc;
   logic signed [PROD_W-1:0] sh6, sh20, sh24, sh34, bsat;
   logic signed [NUM_W-1:0]  num;
   logic [NUM_W-1:0]         num_mag;
   logic [DEN_W-1:0]         det, den;
   logic                     div_done, sqrt_done;
   logic signed [SPIN_W-1:0] div_q;
   logic [SPIN_W-1:0]        root;

   assign field_in[0] = signed'(field_x);
   assign field_in[1] = signed'(field_y);
   assign field_in[2] = signed'(field_z);

   // saturate wide fields to 32 bits
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fext[i] = EXT_W'(field_in[i]);
         if (fext[i] > F_MAX)
            fsat[i] = F_MAX[SPIN_W-1:0];
         else if (fext[i] < F_MIN)
            fsat[i] = F_MIN[SPIN_W-1:0];
         else
            fsat[i] = fext[i][SPIN_W-1:0];
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      case (cmd.idx)
         2'd0: begin
            jx = 2'd1;
            kx = 2'd2;
         end
         2'd1: begin
            jx = 2'd2;
            kx = 2'd0;
         end
         default: begin
            jx = 2'd0;
            kx = 2'd1;
         end
      endcase
      vsrc = cmd.src_r ? r_ff[cmd.idx] : f_ff[cmd.idx];
      ma   = '0;
      mc   = '0;
      case (cmd.mop)
         MOP_B: begin
            ma = signed'({1'b0, gain});
            mc = MUL_W'(f_ff[cmd.idx]);
         end
         MOP_Q: begin
            ma = MUL_W'(b_ff[cmd.idx]);
            mc = MUL_W'(b_ff[cmd.idx]);
         end
         MOP_D: begin
            ma = MUL_W'(b_ff[cmd.idx]);
            mc = MUL_W'(s_ff[cmd.idx]);
         end
         MOP_NP: begin
            ma = MUL_W'(b_ff[jx]);
            mc = MUL_W'(s_ff[kx]);
         end
         MOP_NM: begin
            ma = MUL_W'(b_ff[kx]);
            mc = MUL_W'(s_ff[jx]);
         end
         MOP_NDB: begin
            ma = MUL_W'(d_ff);
            mc = MUL_W'(b_ff[cmd.idx]);
         end
         MOP_SQ: begin
            ma = MUL_W'(vsrc);
            mc = MUL_W'(vsrc);
         end
         default: begin
            ma = '0;
            mc = '0;
         end
      endcase
      prod_in = ma * mc;
   end

   // floor shifts of the registered product
   always_comb begin
      sh6  = prod_ff >>> 6;
      sh20 = prod_ff >>> 20;
      sh24 = prod_ff >>> 24;
      sh34 = prod_ff >>> 34;
      if (sh24 > B_MAX)
         bsat = B_MAX;
      else if (sh24 < B_MIN)
         bsat = B_MIN;
      else
         bsat = sh24;
   end

   // divider operands
   always_comb begin
      det     = DEN_W'(q_ff[NUM_W-1:20]) + (DEN_W'(1) << 20);
      num     = cmd.div_unit ? NUM_W'(vsrc) : n_ff[cmd.idx];
      num_mag = num[NUM_W-1] ? NUM_W'(0) - num : num;
      den     = cmd.div_unit ? DEN_W'(root) : det;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_op_ff <= MOP_NONE;
      end else begin
         tag_op_ff <= cmd.mop;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      tag_idx_ff <= cmd.idx;
      if (cmd.load) begin
         for (int i = 0; i < 3; i++) f_ff[i] <= fsat[i];
         q_ff    <= '0;
         d_ff    <= '0;
         ss_ff   <= '0;
         zero_ff <= 1'b0;
      end
      case (tag_op_ff)
         MOP_B:   b_ff[tag_idx_ff] <= bsat[SPIN_W-1:0];
         MOP_Q:   q_ff <= q_ff + prod_ff[NUM_W-1:0];
         MOP_D:   d_ff <= d_ff + sh34[SPIN_W-1:0];
         MOP_NP:  n_ff[tag_idx_ff] <= NUM_W'(s_ff[tag_idx_ff]) + sh20[NUM_W-1:0];
         MOP_NM:  n_ff[tag_idx_ff] <= n_ff[tag_idx_ff] - sh20[NUM_W-1:0];
         MOP_NDB: n_ff[tag_idx_ff] <= n_ff[tag_idx_ff] + sh6[NUM_W-1:0];
         MOP_SQ:  ss_ff <= ss_ff + prod_ff[NUM_W-1:0];
         default: ;
      endcase
      if (cmd.div_store)
         r_ff[cmd.idx] <= div_q;
      if (cmd.set_zero) begin
         for (int i = 0; i < 3; i++) r_ff[i] <= '0;
         zero_ff <= 1'b1;
      end
      if (cmd.publish) begin
         out_x_ff    <= r_ff[0];
         out_y_ff    <= r_ff[1];
         out_z_ff    <= r_ff[2];
         out_zero_ff <= zero_ff;
      end
   end

   // spin state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) s_ff[i] <= '0;
      end else if (cmd.publish) begin
         for (int i = 0; i < 3; i++) s_ff[i] <= r_ff[i];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   spbe_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .num_mag (num_mag),
      .num_neg (num[NUM_W-1]),
      .unit    (cmd.div_unit),
      .den     (den),
      .done    (div_done),
      .quot    (div_q)
   );

   spbe_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .value (ss_ff),
      .done  (sqrt_done),
      .root  (root)
   );

   always_comb begin
      status.norm      = norm;
      status.div_done  = div_done;
      status.sqrt_done = sqrt_done;
      status.mag_zero  = (root == '0);
      status.out_busy  = rsp_valid_ff & ~rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign spin_x     = out_x_ff;
   assign spin_y     = out_y_ff;
   assign spin_z     = out_z_ff;
   assign zero_field = out_zero_ff;

endmodule

@@ rtl/spbe_ctrl.sv @@
// Sequencer: issues multiply micro-ops, starts divides and the square root.
// Depends on spbe_pkg.
`timescale 1ns / 1ps
module spbe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_mode,
   output logic                 req_ready,
   input  spbe_pkg::status_type status,
   output spbe_pkg::cmd_type    cmd
);
   import spbe_pkg::*;

   localparam logic [4:0] PREC_LAST = 5'd17;

   typedef struct packed {
      mop_type    mop;
      logic [1:0] idx;
   } uop_type;

   // precession step: b, |b|^2, b.s, cross terms, then the (b.s)b term
   function automatic uop_type prec_uop(input logic [4:0] step);
      uop_type u;
      case (step)
         5'd0:    u = '{MOP_B,   2'd0};
         5'd1:    u = '{MOP_B,   2'd1};
         5'd2:    u = '{MOP_B,   2'd2};
         5'd3:    u = '{MOP_Q,   2'd0};
         5'd4:    u = '{MOP_Q,   2'd1};
         5'd5:    u = '{MOP_Q,   2'd2};
         5'd6:    u = '{MOP_D,   2'd0};
         5'd7:    u = '{MOP_D,   2'd1};
         5'd8:    u = '{MOP_D,   2'd2};
         5'd9:    u = '{MOP_NP,  2'd0};
         5'd10:   u = '{MOP_NM,  2'd0};
         5'd11:   u = '{MOP_NP,  2'd1};
         5'd12:   u = '{MOP_NM,  2'd1};
         5'd13:   u = '{MOP_NP,  2'd2};
         5'd14:   u = '{MOP_NM,  2'd2};
         5'd15:   u = '{MOP_NDB, 2'd0};
         5'd16:   u = '{MOP_NDB, 2'd1};
         5'd17:   u = '{MOP_NDB, 2'd2};
         default: u = '{MOP_NONE, 2'd0};
      endcase
      return u;
   endfunction

   state_type  state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [1:0] idx_ff, idx_in;
   logic       unit_ff, unit_in;
   logic       src_r_ff, src_r_in;
   uop_type    uop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         idx_ff   <= '0;
         unit_ff  <= 1'b0;
         src_r_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         idx_ff   <= idx_in;
         unit_ff  <= unit_in;
         src_r_ff <= src_r_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      idx_in    = idx_ff;
      unit_in   = unit_ff;
      src_r_in  = src_r_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.mop   = MOP_NONE;
      cmd.idx   = idx_ff;
      cmd.src_r = src_r_ff;
      cmd.div_unit = unit_ff;
      uop       = prec_uop(step_ff);
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               idx_in   = '0;
               src_r_in = 1'b0;
               state_in = req_mode ? ST_PREC : ST_SQ;
            end
         end
         ST_PREC: begin
            cmd.mop = uop.mop;
            cmd.idx = uop.idx;
            if (step_ff == PREC_LAST)
               state_in = ST_PFLUSH;
            else
               step_in = step_ff + 5'd1;
         end
         ST_PFLUSH: begin
            idx_in   = '0;
            unit_in  = 1'b0;
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               if (idx_ff == 2'd2) begin
                  if (!unit_ff && status.norm) begin
                     idx_in   = '0;
                     src_r_in = 1'b1;
                     state_in = ST_SQ;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_SQ: begin
            cmd.mop = MOP_SQ;
            if (idx_ff == 2'd2)
               state_in = ST_SFLUSH;
            else
               idx_in = idx_ff + 2'd1;
         end
         ST_SFLUSH: begin
            state_in = ST_SQRT_GO;
         end
         ST_SQRT_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in       = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (status.sqrt_done) begin
               if (status.mag_zero) begin
                  cmd.set_zero = 1'b1;
                  state_in     = ST_DONE;
               end else begin
                  idx_in   = '0;
                  unit_in  = 1'b1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // a divide result arriving outside the wait state would be dropped
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divide finished while sequencer not waiting");

   a_sqrt_done_waited: assert property (@(posedge clock) disable iff (reset)
      status.sqrt_done |-> state_ff == ST_SQRT_WAIT)
      else $error("square root finished while sequencer not waiting");

   a_div_not_instant: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !status.div_done)
      else $error("divider reported done right after start");

endmodule

@@ rtl/spin_precession_backward_euler.sv @@
// Top level of the spin precession block: stream ports, config registers,
// sequencer and datapath. Depends on spbe_pkg, spbe_ctrl and spbe_datapath.
`timescale 1ns / 1ps
// Usage
//  - req_* stream: one word per step. req_tuser is the mode (0 align spin to
//    the field direction, 1 one backward-Euler precession step); req_tdata holds
//    field_x, field_y, field_z (signed Q4.28 tesla) from the low bits up.
//  - rsp_* stream: one word per request with the new spin (signed Q2.30) in
//    rsp_tdata and the zero-vector flag in rsp_tuser.
//  - csr_* port: index 0 gain_per_tesla (unsigned Q16.16), index 1
//    normalize_enable. csr_ready is always high; write only while idle.
//  - One item at a time: a new word is taken only after the previous result is
//    published, and can be taken in the cycle in which rsp_tvalid rises. The
//    divider and square root are bit-serial; the 18 precession products of a
//    step go through one shared 33x33 multiplier, one per cycle.
//  - req_tready is high only while the sequencer is idle; a finished word sits
//    in the output register, so a new request is taken while it waits.
//  - The sequencer holds a finished word while the last one waits on rsp_tready.
//  - Reset clears the spin to zero, gain to 12006195 and enables normalization.
module spin_precession_backward_euler #(
   parameter int DATA_WIDTH = spbe_pkg::DATA_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // field_x, field_y, field_z, zero pad to bytes
   input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]     req_tdata,
   // mode
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // spin_x, spin_y, spin_z
   output logic [3*spbe_pkg::SPIN_W-1:0]         rsp_tdata,
   // zero_field
   output logic                                  rsp_tuser,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [0:0]                            csr_index,
   input  logic [31:0]                           csr_data
);
   import spbe_pkg::*;

   logic [31:0]        gain_ff, gain_in;
   logic               norm_ff, norm_in;
   cmd_type            cmd;
   status_type         status;
   logic [SPIN_W-1:0]  spin_x, spin_y, spin_z;

   // config registers
   always_comb begin
      gain_in = gain_ff;
      norm_in = norm_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GAIN: gain_in = csr_data;
            CSR_NORM: norm_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         norm_ff <= NORM_RESET;
      end else begin
         gain_ff <= gain_in;
         norm_ff <= norm_in;
      end
   end

   assign csr_ready = 1'b1;

   spbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_mode  (req_tuser),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   spbe_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .gain       (gain_ff),
      .norm       (norm_ff),
      .field_x    (req_tdata[DATA_WIDTH-1:0]),
      .field_y    (req_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
      .field_z    (req_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .spin_x     (spin_x),
      .spin_y     (spin_y),
      .spin_z     (spin_z),
      .zero_field (rsp_tuser)
   );

   assign rsp_tdata = {spin_z, spin_y, spin_x};

endmodule

@@ tb/sv/tb_spin_precession_backward_euler.sv @@
// Self-checking bench for spin_precession_backward_euler: directed table, then random
// field words checked against a bit-exact spin predictor. Depends on spbe_pkg and the RTL.
`timescale 1ns / 1ps
module tb_spin_precession_backward_euler;
   import spbe_pkg::*;

   localparam int  CYCLE_LIMIT   = 3_000_000;
   localparam int  SETTLE_CYCLES = 400;
   localparam int  RANDOM_ITEMS  = 1250;
   localparam int  LONG_HOLD     = 3000;
   localparam longint B_LIMIT    = longint'(2047) << 20;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [95:0]  req_tdata;    // field_x, field_y, field_z
   logic         req_tuser;    // mode
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;    // spin_x, spin_y, spin_z
   logic         rsp_tuser;    // zero_field
   logic         csr_valid;
   logic         csr_ready;
   logic [0:0]   csr_index;
   logic [31:0]  csr_data;

   spin_precession_backward_euler dut (.*);

   typedef struct {
      logic [31:0] sx;
      logic [31:0] sy;
      logic [31:0] sz;
      logic        zero;
   } spin_word_t;

   typedef struct {
      logic        mode;
      logic [31:0] fx;
      logic [31:0] fy;
      logic [31:0] fz;
      logic        typed;      // expected word written out in the row
      spin_word_t  want;
   } field_row_t;

   // predictor copy of the block's state and registers
   logic [31:0]  gain_q16;
   logic         norm_on;
   int           spin_q30 [3];

   spin_word_t   spin_expected_q[$];
   int           error_count;
   int           words_checked;
   int           zero_flags_seen;
   int           mode1_words;
   longint       cycle_count;
   bit           hold_request;

   // ---------------------------------------------------------------- predictor
   function automatic logic [63:0] abs64(longint v);
      return v < 0 ? 64'd0 - 64'(v) : 64'(v);
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv >>= 2;
      end
      return r;
   endfunction

   // trunc(n * 2^k / den), saturated to 32-bit signed
   function automatic int scaled_div(longint n, logic [63:0] den, int k);
      logic [63:0] m;
      logic [63:0] q;
      logic [63:0] r;
      longint      res;
      m = abs64(n);
      q = m / den;
      r = m % den;
      q = (q << k) + ((r << k) / den);
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      res = n < 0 ? -longint'(q) : longint'(q);
      if (res > 2147483647) res = 2147483647;
      return int'(res);
   endfunction

   // unit vector in Q2.30; returns 1 when the vector is zero
   function automatic bit make_unit(input longint v [3], output int o [3]);
      logic [63:0] ss;
      logic [63:0] m;
      ss = 0;
      for (int i = 0; i < 3; i++) ss += abs64(v[i]) * abs64(v[i]);
      m = floor_sqrt(ss);
      if (m == 0) begin
         o = '{0, 0, 0};
         return 1;
      end
      for (int i = 0; i < 3; i++) o[i] = scaled_div(v[i], m, 30);
      return 0;
   endfunction

   function automatic spin_word_t predict_spin(logic mode, logic [95:0] fields);
      longint      f [3];
      longint      s [3];
      longint      b [3];
      longint      n [3];
      longint      t [3];
      longint      d;
      logic [63:0] q;
      logic [63:0] det;
      int          r [3];
      bit          zero;
      spin_word_t  w;
      for (int i = 0; i < 3; i++) begin
         f[i] = longint'($signed(fields[32*i +: 32]));
         s[i] = longint'(spin_q30[i]);
      end
      zero = 0;
      if (mode == 1'b0) begin
         zero = make_unit(f, r);
      end else begin
         q = 0;
         d = 0;
         for (int i = 0; i < 3; i++) begin
            b[i] = (longint'({32'd0, gain_q16}) * f[i]) >>> 24;
            if (b[i] > B_LIMIT) b[i] = B_LIMIT;
            if (b[i] < -B_LIMIT) b[i] = -B_LIMIT;
            q += abs64(b[i]) * abs64(b[i]);
            d += (b[i] * s[i]) >>> 34;
         end
         det = (q >> 20) + (64'd1 << 20);
         for (int i = 0; i < 3; i++) begin
            n[i] = s[i] + ((d * b[i]) >>> 6) + ((b[(i+1)%3] * s[(i+2)%3]) >>> 20)
                   - ((b[(i+2)%3] * s[(i+1)%3]) >>> 20);
            r[i] = scaled_div(n[i], det, 20);
         end
         if (norm_on) begin
            for (int i = 0; i < 3; i++) t[i] = r[i];
            zero = make_unit(t, r);
         end
      end
      spin_q30 = r;
      w.sx = r[0];
      w.sy = r[1];
      w.sz = r[2];
      w.zero = zero;
      return w;
   endfunction

   // ---------------------------------------------------------------- clock, watchdog
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words pending", cycle_count,
                  spin_expected_q.size());
         $display("spin_precession_backward_euler test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- result side
   // tready stall per word drawn at random; a hold request parks tready low for a long stretch
   int stall_left;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left  = 0;
      end else if (hold_request) begin
         hold_request = 0;
         stall_left   = LONG_HOLD;
         rsp_tready  <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // checker: every accepted spin word against the oldest expectation
   always @(posedge clock) begin
      spin_word_t w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         if (spin_expected_q.size() == 0) begin
            $error("spin word with no expectation pending: %h", rsp_tdata);
            error_count++;
         end else begin
            w = spin_expected_q.pop_front();
            words_checked++;
            if (rsp_tuser) zero_flags_seen++;
            if (rsp_tdata[31:0] !== w.sx) begin
               $error("spin_x expected %h got %h", w.sx, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[63:32] !== w.sy) begin
               $error("spin_y expected %h got %h", w.sy, rsp_tdata[63:32]);
               error_count++;
            end
            if (rsp_tdata[95:64] !== w.sz) begin
               $error("spin_z expected %h got %h", w.sz, rsp_tdata[95:64]);
               error_count++;
            end
            if (rsp_tuser !== w.zero) begin
               $error("zero_field expected %b got %b", w.zero, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- request side
   // expectation built at the edge the field word is taken; a typed row overrides
   bit          row_typed;
   spin_word_t  row_want;
   always @(posedge clock) begin
      spin_word_t w;
      if (!reset && req_tvalid && req_tready) begin
         w = predict_spin(req_tuser, req_tdata);
         if (req_tuser) mode1_words++;
         spin_expected_q.push_back(row_typed ? row_want : w);
      end
   end

   // drives one field word after a random gap; valid stays high when there is no gap
   task automatic send_field(logic mode, logic [31:0] fx, logic [31:0] fy,
                             logic [31:0] fz, bit typed, spin_word_t want);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {fz, fy, fx};
      row_typed   = typed;
      row_want    = want;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
   endtask

   task automatic drain_spin();
      req_tvalid <= 1'b0;
      while (spin_expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // register write, only called with the block idle
   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      drain_spin();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_GAIN) gain_q16 = value;
      else norm_on = value[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] random_field();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return $urandom();
      if (pick == 1) return 32'd0;
      // mostly modest fields so b stays in the unsaturated range
      return 32'($signed($urandom()) >>> $urandom_range(4, 31));
   endfunction

   task automatic random_burst(int count);
      logic mode;
      logic [31:0] fx;
      logic [31:0] fy;
      logic [31:0] fz;
      spin_word_t none;
      none = '{default: '0};
      for (int i = 0; i < count; i++) begin
         mode = ($urandom_range(0, 9) < 8);
         fx = random_field();
         fy = random_field();
         fz = random_field();
         if ($urandom_range(0, 49) == 0) begin
            fx = 0; fy = 0; fz = 0;
         end
         send_field(mode, fx, fy, fz, 0, none);
      end
   endtask

   // directed rows: reset state, zero field, extremes, saturation
   field_row_t directed [] = '{
      // step with the reset spin of zero hits the zero vector at normalization
      '{1'b1, 32'h1000_0000, 0, 0, 1, '{0, 0, 0, 1}},
      // zero field alignment
      '{1'b0, 0, 0, 0, 1, '{0, 0, 0, 1}},
      '{1'b0, 32'h1000_0000, 0, 0, 1, '{32'h4000_0000, 0, 0, 0}},
      '{1'b0, 0, 32'h8000_0000, 0, 1, '{0, 32'hC000_0000, 0, 0}},
      '{1'b0, 0, 0, 32'h7FFF_FFFF, 1, '{0, 0, 32'h4000_0000, 0}},
      '{1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 0, '{0, 0, 0, 0}},
      '{1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '{0, 0, 0, 0}},
      '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, '{0, 0, 0, 0}},
      '{1'b0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 0, '{0, 0, 0, 0}},
      '{1'b1, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 0, '{0, 0, 0, 0}},
      '{1'b1, 0, 0, 0, 0, '{0, 0, 0, 0}},
      '{1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 0, '{0, 0, 0, 0}},
      '{1'b1, 32'h0010_0000, 32'hFFF0_0000, 32'h0008_0000, 0, '{0, 0, 0, 0}}
   };

   initial begin
      spin_word_t none;
      none = '{default: '0};
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = CSR_GAIN;
      csr_data     = '0;
      hold_request = 0;
      row_typed    = 0;
      cycle_count  = 0;
      error_count  = 0;
      gain_q16     = 32'd12006195;
      norm_on      = 1'b1;
      spin_q30     = '{0, 0, 0};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_field(directed[i].mode, directed[i].fx, directed[i].fy, directed[i].fz,
                    directed[i].typed, directed[i].want);

      // saturating gain, then zero gain, then normalization off, each with a few field words
      write_csr(CSR_GAIN, 32'hFFFF_FFFF);
      send_field(1'b0, 32'h0100_0000, 32'h0200_0000, 32'h0080_0000, 0, none);
      send_field(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 0, none);
      write_csr(CSR_GAIN, 32'd0);
      send_field(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, none);
      write_csr(CSR_NORM, 1'b0);
      send_field(1'b1, 32'h0400_0000, 0, 0, 0, none);

      // random phases through several register settings
      write_csr(CSR_GAIN, 32'd12006195);
      random_burst(250);                       // unnormalized, default gain
      write_csr(CSR_NORM, 1'b1);
      // long receiver hold while words keep coming: input stalls behind it
      hold_request = 1;
      random_burst(250);
      // sender pauses until every expected word is back
      req_tvalid <= 1'b0;
      while (spin_expected_q.size() != 0) @(negedge clock);
      random_burst(50);
      write_csr(CSR_GAIN, $urandom());
      random_burst(250);
      write_csr(CSR_GAIN, 32'hFFFF_FFFF);
      random_burst(100);
      write_csr(CSR_NORM, 1'b0);
      write_csr(CSR_GAIN, $urandom_range(0, 32'h00FF_FFFF));
      random_burst(200);
      write_csr(CSR_NORM, 1'b1);
      write_csr(CSR_GAIN, 32'd0);
      random_burst(RANDOM_ITEMS - 1100);

      drain_spin();
      if (spin_expected_q.size() != 0) begin
         $error("%0d expected spin words never arrived", spin_expected_q.size());
         error_count++;
      end
      $display("checked %0d spin words (%0d precession steps, %0d zero-vector flags)",
               words_checked, mode1_words, zero_flags_seen);
      $display("gain swept from 0 to full scale, normalization on and off, %0d mismatches",
               error_count);
      if (error_count == 0)
         $display("spin_precession_backward_euler test passed");
      else
         $display("spin_precession_backward_euler test failed");
      $finish;
   end

endmodule
